### src/sdi3glb_pkg.sv
// ----------------------------------------------------------------------------
// sdi3glb_pkg
// Shared types, constants and helper functions of the level B line checker.
// ----------------------------------------------------------------------------
package sdi3glb_pkg;

  localparam int WORD_W      = 10;
  localparam int POS_W       = 13;
  localparam int LEN_W       = 14;
  localparam int PWIDTH_W    = 12;
  localparam int ASTART_W    = 13;
  localparam int HEIGHT_W    = 11;
  localparam int IDX_W       = 12;
  localparam int LINE_W      = 14;
  localparam int HALF_W      = 7;
  localparam int PREV_W      = 15;
  localparam int CFG_DATA_W  = 13;
  localparam int TRS_WORDS   = 16;
  localparam int MAX_WIDTH   = 2048;

  localparam logic [WORD_W-1:0] TRS_ONES  = 10'h3ff;
  localparam logic [WORD_W-1:0] TRS_ZEROS = 10'h000;

  localparam logic [PWIDTH_W-1:0] PWIDTH_RESET = 12'd1920;
  localparam logic [ASTART_W-1:0] ASTART_RESET = 13'd1120;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 11'd1080;
  localparam logic [PWIDTH_W-1:0] PWIDTH_MAX   = PWIDTH_W'(MAX_WIDTH);

  // Positions of the line number words, the XYZ word and the EAV end inside the line
  localparam logic [POS_W-1:0] POS_LINE_LOW  = 13'd16;
  localparam logic [POS_W-1:0] POS_LINE_HIGH = 13'd20;
  localparam logic [POS_W-1:0] POS_XYZ       = 13'd12;
  localparam logic [POS_W-1:0] POS_EAV_END   = 13'd15;

  typedef enum logic [1:0] {
    CFG_PICTURE_WIDTH = 2'd0,
    CFG_ACTIVE_START  = 2'd1,
    CFG_FRAME_HEIGHT  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [PWIDTH_W-1:0] picture_width;
    logic [ASTART_W-1:0] active_start_word;
    logic [HEIGHT_W-1:0] frame_height;
  } cfg_t;

  // Per-word position info from the line tracker
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             line_start;
    logic             eol;
  } pos_info_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic              in_range;
    logic              in_seq;
  } line_status_t;

  typedef struct packed {
    logic eav_ok;
    logic sav_ok;
  } trs_status_t;

  function automatic logic eav_xyz_allowed(input logic [WORD_W-1:0] v);
    return v == 10'h274 || v == 10'h2d8 || v == 10'h368 || v == 10'h3c4;
  endfunction

  function automatic logic sav_xyz_allowed(input logic [WORD_W-1:0] v);
    return v == 10'h200 || v == 10'h2ac || v == 10'h31c || v == 10'h3b0;
  endfunction

endpackage

### src/sdi3glb_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdi3glb_cfg_regs
// Configuration register file: picture width, active start and frame height.
// ----------------------------------------------------------------------------
module sdi3glb_cfg_regs import sdi3glb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.picture_width     <= PWIDTH_RESET;
      cfg.active_start_word <= ASTART_RESET;
      cfg.frame_height      <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // index beyond the list is dropped
      if (cfg_index == CFG_PICTURE_WIDTH) begin
        cfg.picture_width <= cfg_data[PWIDTH_W-1:0];
      end
      if (cfg_index == CFG_ACTIVE_START) begin
        cfg.active_start_word <= cfg_data[ASTART_W-1:0];
      end
      if (cfg_index == CFG_FRAME_HEIGHT) begin
        cfg.frame_height <= cfg_data[HEIGHT_W-1:0];
      end
    end
  end

endmodule

### src/sdi3glb_line_track.sv
// ----------------------------------------------------------------------------
// sdi3glb_line_track
// Word position counter, line end detection and line number checks.
// ----------------------------------------------------------------------------
module sdi3glb_line_track import sdi3glb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [WORD_W-1:0] word,
  input  cfg_t              cfg,
  output pos_info_t         pinfo,
  output line_status_t      lstat
);

  logic [POS_W-1:0]    pos;
  logic [HALF_W-1:0]   line_low;
  logic [HALF_W-1:0]   line_high;
  logic [PREV_W-1:0]   previous_line;

  logic [PWIDTH_W-1:0] width_eff;
  logic [LEN_W-1:0]    line_len;
  logic [LEN_W-1:0]    pos_plus1;
  logic [HALF_W-1:0]   line_low_next;
  logic [HALF_W-1:0]   line_high_next;
  logic [LINE_W-1:0]   line_cur;
  logic [PREV_W-1:0]   prev_plus1;

  always_comb begin
    width_eff = cfg.picture_width;
    if (cfg.picture_width == '0) begin
      width_eff = PWIDTH_W'(1);
    end else if (cfg.picture_width > PWIDTH_MAX) begin
      width_eff = PWIDTH_MAX;
    end
    line_len  = {width_eff, 2'b00};
    pos_plus1 = {1'b0, pos} + LEN_W'(1);

    pinfo.pos        = pos;
    pinfo.line_start = (pos == '0);
    pinfo.eol        = (pos_plus1 >= line_len);

    // drop the previous line's number bits at line start
    line_low_next  = pinfo.line_start ? '0 : line_low;
    line_high_next = pinfo.line_start ? '0 : line_high;
    if (pos == POS_LINE_LOW) begin
      line_low_next = word[8:2];
    end
    if (pos == POS_LINE_HIGH) begin
      line_high_next = word[8:2];
    end
    line_cur   = {line_high_next, line_low_next};
    prev_plus1 = previous_line + PREV_W'(1);

    lstat.line_number = line_cur;
    lstat.in_range    = (line_cur != '0) &&
                        (line_cur <= {{(LINE_W-HEIGHT_W){1'b0}}, cfg.frame_height});
    lstat.in_seq      = (previous_line == {{(PREV_W-HEIGHT_W){1'b0}}, cfg.frame_height}) ||
                        ({1'b0, line_cur} == prev_plus1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      line_low      <= '0;
      line_high     <= '0;
      previous_line <= '1;
    end else if (step) begin
      line_low  <= line_low_next;
      line_high <= line_high_next;
      if (pinfo.eol) begin
        pos           <= '0;
        previous_line <= {1'b0, line_cur};
      end else begin
        pos <= pos_plus1[POS_W-1:0];
      end
    end
  end

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    step && !pinfo.eol |=> pos == $past(pos) + POS_W'(1))
    else $error("position did not advance by one");

  a_pos_wrap: assert property (@(posedge clk) disable iff (rst)
    step && pinfo.eol |=> pos == '0 && previous_line == {1'b0, $past(line_cur)})
    else $error("line end did not restart position or record line number");

  a_no_step_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(pos) && $stable(previous_line))
    else $error("line state changed without an item");

endmodule

### src/sdi3glb_trs_check.sv
// ----------------------------------------------------------------------------
// sdi3glb_trs_check
// EAV check at line start and SAV check over the last sixteen words.
// ----------------------------------------------------------------------------
module sdi3glb_trs_check import sdi3glb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [WORD_W-1:0] word,
  input  cfg_t              cfg,
  input  pos_info_t         pinfo,
  output trs_status_t       tstat
);

  logic [WORD_W-1:0] recent [TRS_WORDS];
  logic [WORD_W-1:0] recent_next [TRS_WORDS];
  logic              eav_match;
  logic              sav_seen;
  logic [WORD_W-1:0] xyz_word;

  logic              eav_next;
  logic              sav_next;
  logic              window_ok;
  logic              sav_at_end;
  logic [LEN_W-1:0]  pos_plus1;

  always_comb begin
    for (int k = 0; k < TRS_WORDS - 1; k++) begin
      recent_next[k] = recent[k+1];
    end
    recent_next[TRS_WORDS-1] = word;

    window_ok = sav_xyz_allowed(recent_next[12]);
    for (int k = 0; k < 4; k++) begin
      if (recent_next[k] != TRS_ONES) window_ok = 1'b0;
    end
    for (int k = 4; k < 12; k++) begin
      if (recent_next[k] != TRS_ZEROS) window_ok = 1'b0;
    end
    for (int k = 13; k < TRS_WORDS; k++) begin
      if (recent_next[k] != recent_next[12]) window_ok = 1'b0;
    end

    eav_next = pinfo.line_start ? 1'b1 : eav_match;
    if (pinfo.pos < POS_W'(4)) begin
      if (word != TRS_ONES) eav_next = 1'b0;
    end else if (pinfo.pos < POS_XYZ) begin
      if (word != TRS_ZEROS) eav_next = 1'b0;
    end else if (pinfo.pos == POS_XYZ) begin
      if (!eav_xyz_allowed(word)) eav_next = 1'b0;
    end else if (pinfo.pos <= POS_EAV_END) begin
      if (word != xyz_word) eav_next = 1'b0;
    end

    pos_plus1  = {1'b0, pinfo.pos} + LEN_W'(1);
    sav_at_end = (cfg.active_start_word >= ASTART_W'(TRS_WORDS)) &&
                 (pos_plus1 == {1'b0, cfg.active_start_word});
    sav_next   = sav_at_end ? window_ok : (pinfo.line_start ? 1'b0 : sav_seen);

    tstat.eav_ok = eav_next && (pinfo.pos >= POS_EAV_END);
    tstat.sav_ok = sav_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eav_match <= 1'b1;
      sav_seen  <= 1'b0;
      xyz_word  <= '0;
      for (int k = 0; k < TRS_WORDS; k++) begin
        recent[k] <= '0;
      end
    end else if (step) begin
      eav_match <= eav_next;
      sav_seen  <= sav_next;
      if (pinfo.pos == POS_XYZ) begin
        xyz_word <= word;
      end
      for (int k = 0; k < TRS_WORDS; k++) begin
        recent[k] <= recent_next[k];
      end
    end
  end

  a_eav_needs_ones: assert property (@(posedge clk) disable iff (rst)
    step && pinfo.pos == '0 && word != TRS_ONES |=> !eav_match)
    else $error("EAV start word mismatch not recorded");

  a_window_tail: assert property (@(posedge clk) disable iff (rst)
    step |=> recent[TRS_WORDS-1] == $past(word))
    else $error("recent word window did not take the item");

  a_sav_clear: assert property (@(posedge clk) disable iff (rst)
    step && pinfo.line_start && !sav_at_end |=> !sav_seen)
    else $error("SAV flag survived line start");

endmodule

### src/sdi3g_levelb_line_checker_unit.sv
// ----------------------------------------------------------------------------
// sdi3g_levelb_line_checker_unit
// 3G-SDI level B line checker: TRS checks, line number checks, line split.
// ----------------------------------------------------------------------------
// One 10-bit word is taken per clock and each word gives exactly one result
// item, which passes the input register and then the result register, with
// the EAV/SAV compare and line number checks as a single combinational pass
// between them. Sustained rate is one word per clock as long as the output
// side does not stall. Status fields are only meaningful on the item marked
// end_of_line and read zero on all others. Configuration is written through
// the cfg port while the block is idle; the block itself does not enforce
// this, and there is no power-up clearing pass.
module sdi3g_levelb_line_checker_unit import sdi3glb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [WORD_W-1:0]     sample_word,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_W-1:0]     data_word,
  output logic                  to_first_line,
  output logic [IDX_W-1:0]      dest_index,
  output logic                  end_of_line,
  output logic                  eav_ok,
  output logic                  sav_ok,
  output logic [LINE_W-1:0]     line_number,
  output logic                  number_in_range,
  output logic                  number_in_sequence
);

  cfg_t              cfg;
  pos_info_t         pinfo;
  line_status_t      lstat;
  trs_status_t       tstat;

  logic              in_q_valid;
  logic [WORD_W-1:0] in_q_word;
  logic              advance;
  logic              step;

  sdi3glb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipe moves when the result register is empty or being taken
  assign advance  = !out_valid || !out_stall;
  assign step     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (advance || !in_q_valid) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((advance || !in_q_valid) && in_valid) begin
      in_q_word <= sample_word;
    end
  end

  sdi3glb_line_track u_line (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .word  (in_q_word),
    .cfg   (cfg),
    .pinfo (pinfo),
    .lstat (lstat)
  );

  sdi3glb_trs_check u_trs (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .word  (in_q_word),
    .cfg   (cfg),
    .pinfo (pinfo),
    .tstat (tstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_word          <= in_q_word;
      to_first_line      <= pinfo.pos[1];
      dest_index         <= {pinfo.pos[POS_W-1:2], pinfo.pos[0]};
      end_of_line        <= pinfo.eol;
      // status only on the last word of the line
      eav_ok             <= pinfo.eol && tstat.eav_ok;
      sav_ok             <= pinfo.eol && tstat.sav_ok;
      line_number        <= pinfo.eol ? lstat.line_number : '0;
      number_in_range    <= pinfo.eol && lstat.in_range;
      number_in_sequence <= pinfo.eol && lstat.in_seq;
    end
  end

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !end_of_line |->
      !eav_ok && !sav_ok && line_number == '0 && !number_in_range && !number_in_sequence)
    else $error("status fields set on a word that is not the line end");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && out_valid)
    else $error("input stalled while the pipe has room");

  a_range_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && number_in_range |-> line_number != '0)
    else $error("line number zero flagged as in range");

endmodule
